// ===== hw/rtl/flru_pkg.sv =====
// Shared types and constants for the frame-protected LRU row cache.
// No dependencies; imported by the core module, not by flru_ram.
package flru_pkg;

  localparam int unsigned ROWS      = 64;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned CNT_W     = $clog2(ROWS + 1);
  localparam int unsigned V_W       = ROW_W + 1;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned FRAME_W   = 64;
  localparam int unsigned ENTRY_W   = KEY_W + FRAME_W;
  localparam int unsigned IN_DATA_W = KEY_W + FRAME_W;
  localparam int unsigned OUT_BITS  = 2 + ROW_W + V_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESULT
  } flru_state_e;

  typedef struct packed {
    logic in_ready;
    logic ram_re;
    logic ram_we;
    logic out_load;
  } flru_ctrl_t;

endpackage

// ===== hw/rtl/flru_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No package dependencies.
module flru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/frame_protected_lru_row_cache_core.sv =====
// Top level of the frame-protected LRU row cache: control FSM, scan datapath,
// result register. Depends on flru_pkg and flru_ram.

// A fully associative tag store of ROWS rows held in one RAM word per row
// (key and last-used frame side by side). Each request word is looked up by
// scanning the claimed rows, one RAM read per cycle, while the oldest row
// used before the current frame is tracked in the same pass. A hit refreshes
// the row's frame; a miss claims the next unused row, or once all rows are in
// use evicts the oldest unprotected row (lowest index on ties), or fails with
// granted low. One request is in work at a time; its scan walks the claimed
// rows through the single RAM read port and stops early on a hit. A finished
// result waits in an output register, so the next request can be taken while
// it is still pending on the output side.
module frame_protected_lru_row_cache_core
  import flru_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [63:0] gradient_key, [127:64] frame_number
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [0] granted, [1] fresh_row, [7:2] row_index, [14:8] v_coordinate, [15] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  flru_state_e state_q, state_d;
  flru_ctrl_t  ctrl;

  logic [KEY_W-1:0]   key_q;
  logic [FRAME_W-1:0] frame_q;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   addr_q, addr_d;
  logic               chk_vld_q;
  logic [ROW_W-1:0]   chk_idx_q;
  logic               found_q, found_d;
  logic [FRAME_W-1:0] oldest_q, oldest_d;
  logic [ROW_W-1:0]   victim_q, victim_d;
  logic               res_gnt_q, res_gnt_d;
  logic               res_fresh_q, res_fresh_d;
  logic               res_fill_q, res_fill_d;
  logic [ROW_W-1:0]   res_row_q, res_row_d;
  logic               out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic               in_acc;
  logic               issue;
  logic               hit;
  logic               scan_done;
  logic               table_full;
  logic [ENTRY_W-1:0] rd_entry;
  logic [KEY_W-1:0]   rd_key;
  logic [FRAME_W-1:0] rd_frame;
  logic [V_W-1:0]     res_v;

  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_key     = rd_entry[KEY_W-1:0];
  assign rd_frame   = rd_entry[ENTRY_W-1:KEY_W];
  assign table_full = (used_q == CNT_W'(ROWS));
  assign issue      = (state_q == ST_SCAN) && (addr_q != used_q) && !hit;
  assign hit        = (state_q == ST_SCAN) && chk_vld_q && (rd_key == key_q);
  assign scan_done  = (state_q == ST_SCAN) && !chk_vld_q && (addr_q == used_q);

  flru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROWS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.ram_we),
    .waddr_i (res_row_q),
    .wdata_i ({frame_q, key_q}),
    .re_i    (ctrl.ram_re),
    .raddr_i (addr_q[ROW_W-1:0]),
    .rdata_o (rd_entry)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_SCAN;
      ST_SCAN:   if (hit || scan_done) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_RESULT;
      ST_RESULT: if (!out_vld_q || m_axis_tready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_SCAN:   ctrl.ram_re   = issue;
      ST_COMMIT: ctrl.ram_we   = res_gnt_q;
      ST_RESULT: ctrl.out_load = !out_vld_q || m_axis_tready_i;
      default:   ctrl = '0;
    endcase
  end

  assign s_axis_tready_o = ctrl.in_ready;

  // Scan datapath: address walk, victim tracking, decision.
  always_comb begin
    addr_d      = addr_q;
    found_d     = found_q;
    oldest_d    = oldest_q;
    victim_d    = victim_q;
    res_gnt_d   = res_gnt_q;
    res_fresh_d = res_fresh_q;
    res_fill_d  = res_fill_q;
    res_row_d   = res_row_q;
    used_d      = used_q;

    if (in_acc) begin
      addr_d  = '0;
      found_d = 1'b0;
    end
    if (issue) begin
      addr_d = addr_q + CNT_W'(1);
    end

    if ((state_q == ST_SCAN) && chk_vld_q && (rd_frame < frame_q) &&
        (!found_q || (rd_frame < oldest_q))) begin
      found_d  = 1'b1;
      oldest_d = rd_frame;
      victim_d = chk_idx_q;
    end

    if (hit) begin
      res_gnt_d   = 1'b1;
      res_fresh_d = 1'b0;
      res_fill_d  = 1'b0;
      res_row_d   = chk_idx_q;
    end else if (scan_done) begin
      if (!table_full) begin
        res_gnt_d   = 1'b1;
        res_fresh_d = 1'b1;
        res_fill_d  = 1'b1;
        res_row_d   = used_q[ROW_W-1:0];
      end else if (found_q) begin
        res_gnt_d   = 1'b1;
        res_fresh_d = 1'b1;
        res_fill_d  = 1'b0;
        res_row_d   = victim_q;
      end else begin
        res_gnt_d   = 1'b0;
        res_fresh_d = 1'b0;
        res_fill_d  = 1'b0;
        res_row_d   = '0;
      end
    end

    if ((state_q == ST_COMMIT) && res_fill_q) begin
      used_d = used_q + CNT_W'(1);
    end
  end

  // Result register toward the master side.
  assign res_v = res_gnt_q ? {res_row_q, 1'b1} : '0;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (ctrl.out_load) begin
      out_vld_d  = 1'b1;
      out_data_d = OUT_DATA_W'({res_v, res_row_q, res_fresh_q, res_gnt_q});
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      addr_q    <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      res_gnt_q <= 1'b0;
      res_fill_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      addr_q     <= addr_d;
      chk_vld_q  <= issue;
      found_q    <= found_d;
      res_gnt_q  <= res_gnt_d;
      res_fill_q <= res_fill_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q   <= s_axis_tdata_i[KEY_W-1:0];
      frame_q <= s_axis_tdata_i[IN_DATA_W-1:KEY_W];
    end
    chk_idx_q   <= addr_q[ROW_W-1:0];
    oldest_q    <= oldest_d;
    victim_q    <= victim_d;
    res_fresh_q <= res_fresh_d;
    res_row_q   <= res_row_d;
    out_data_q  <= out_data_d;
  end

  // Fill count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(ROWS))
    else $error("row fill count exceeds table size");

  // Fill count moves only when a commit claims an unused row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> ($past(state_q) == ST_COMMIT) && $past(res_fill_q))
    else $error("row fill count changed outside a fill commit");

  // A failed request reports no fresh row and row zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[OUT_DATA_W-1:1] == '0))
    else $error("failed request carries a nonzero result");

  // An accepted word starts a scan in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN) && (addr_q == '0))
    else $error("accepted word did not start a scan");

endmodule
